>>> rtl/fed_pkg.sv
// fed_pkg: shared constants and types of the feedback echo delay block.
// No dependencies; imported by fed_datapath and the top level.
package fed_pkg;

   // delay line geometry
   localparam int LINE_DEPTH = 16384;
   localparam int ADDR_W     = $clog2(LINE_DEPTH);
   localparam int LINE_W     = 32;

   // field and register widths
   localparam int SAMPLE_W = 16;
   localparam int DELAY_W  = 14;
   localparam int GAIN_W   = 15;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY_LENGTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ECHO_GAIN     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FEEDBACK_GAIN = 2'd2;

   // configuration reset values
   localparam logic [DELAY_W-1:0] DELAY_RESET = 14'd100;
   localparam logic [GAIN_W-1:0]  GAIN_RESET  = 15'd16384;

   // stage enables from the sequencer to the datapath
   typedef struct packed {
      logic load_x;   // capture halved input sample
      logic mul_s;    // echo gain product from line word
      logic mul_b;    // output sum and feedback gain product
   } fed_ctrl_type;

endpackage

>>> rtl/fed_ram.sv
// fed_ram: generic single-write, single-read synchronous RAM, registered read.
// Standalone; instanced by the top level for the delay line.
module fed_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/fed_datapath.sv
// fed_datapath: Q15 gain products, saturating sums and the write-back word.
// Depends on fed_pkg; stage enables come from the top-level sequencer.
module fed_datapath (
   input  logic                               clock,
   input  fed_pkg::fed_ctrl_type              ctrl,
   input  logic signed [fed_pkg::SAMPLE_W-1:0] in_sample,
   input  logic [fed_pkg::GAIN_W-1:0]         echo_gain,
   input  logic [fed_pkg::GAIN_W-1:0]         feedback_gain,
   input  logic                               line_valid,
   input  logic [fed_pkg::LINE_W-1:0]         line_word,
   output logic [fed_pkg::SAMPLE_W-1:0]       y_half,
   output logic [fed_pkg::LINE_W-1:0]         wr_word
);
   import fed_pkg::*;

   logic signed [SAMPLE_W-1:0] smp_adj;
   logic signed [SAMPLE_W-1:0] half_in, half_ff;
   logic [LINE_W-1:0]          delayed;
   logic signed [LINE_W-1:0]   s_prod, b_prod;
   logic [LINE_W-1:0]          s_in, s_ff;
   logic [LINE_W-1:0]          bs_in, bs_ff;
   logic [LINE_W-1:0]          x_word;
   logic [LINE_W:0]            sum_y, sum_d;
   logic [LINE_W-1:0]          y_word;
   logic [SAMPLE_W-1:0]        y_in, y_ff;

   function automatic logic [LINE_W-1:0] sat_add(input logic [LINE_W:0] v);
      logic [LINE_W-1:0] r;
      if (v[LINE_W] != v[LINE_W-1]) begin
         r = v[LINE_W] ? {1'b1, {(LINE_W-1){1'b0}}} : {1'b0, {(LINE_W-1){1'b1}}};
      end else begin
         r = v[LINE_W-1:0];
      end
      return r;
   endfunction

   // halve toward zero: bias negatives by one before the arithmetic shift
   always_comb begin
      smp_adj = in_sample + SAMPLE_W'(in_sample[SAMPLE_W-1]);
      half_in = smp_adj >>> 1;
   end

   // entries not yet written since reset read as zero
   assign delayed = line_valid ? line_word : '0;
   assign x_word  = {half_ff, 16'b0};

   // gains are below one, so the doubled products never overflow 32 bits
   always_comb begin
      s_prod = $signed({1'b0, echo_gain}) * $signed(delayed[LINE_W-1:16]);
      s_in   = {s_prod[LINE_W-2:0], 1'b0};
      b_prod = $signed({1'b0, feedback_gain}) * $signed(s_ff[LINE_W-1:16]);
      bs_in  = {b_prod[LINE_W-2:0], 1'b0};
      sum_y  = {x_word[LINE_W-1], x_word} + {s_ff[LINE_W-1], s_ff};
      y_word = sat_add(sum_y);
      y_in   = y_word[LINE_W-1:16];
      sum_d  = {x_word[LINE_W-1], x_word} + {bs_ff[LINE_W-1], bs_ff};
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_x) begin
         half_ff <= half_in;
      end
      if (ctrl.mul_s) begin
         s_ff <= s_in;
      end
      if (ctrl.mul_b) begin
         y_ff  <= y_in;
         bs_ff <= bs_in;
      end
   end

   assign y_half  = y_ff;
   assign wr_word = sat_add(sum_d);

endmodule

>>> rtl/feedback_echo_delay_top.sv
// feedback_echo_delay_top: feedback echo comb filter over a RAM delay line.
// Depends on fed_pkg, fed_ram and fed_datapath.
//
// Usage:
//   req_* stream carries one signed 16-bit sample per transaction; rsp_*
//   returns one echoed sample for each. csr_* writes delay_length (index 0),
//   echo_gain (1) and feedback_gain (2); it is always ready. The user must
//   write it only while the block is idle; the block does not enforce this.
// Sequence:
//   An accepted sample goes through the line RAM read (registered), the
//   echo gain product, the feedback gain product and the write-back of the
//   new line word, all through the single RAM and the sequencer below. A
//   new sample is taken only once the sequencer is back in idle.
// Reset:
//   Synchronous, active high. Pointer, wrap flag and registers return to
//   their defaults. The line is not swept: entries below the write pointer
//   before the first wrap are the only ones written, every other entry reads
//   as zero, so the block accepts samples right after reset.
// Stall:
//   The result sits in an output register; a new sample is taken while it
//   waits. If the next result is ready and the old one is still held, the
//   sequencer waits until rsp_tready frees the register.
module feedback_echo_delay_top (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] in_sample
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] out_sample
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [fed_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fed_pkg::CSR_DATA_W-1:0] csr_data
);
   import fed_pkg::*;

   localparam int CMP_W = ((DELAY_W > ADDR_W) ? DELAY_W : ADDR_W) + 1;

   typedef enum logic [2:0] {S_IDLE, S_MUL_S, S_MUL_B, S_WR, S_OUT} state_type;

   state_type            state_ff, state_in;
   logic [ADDR_W-1:0]    wp_ff, wp_in;
   logic                 wrapped_ff, wrapped_in;
   logic                 rd_valid_ff, rd_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]  rsp_data_ff, rsp_data_in;

   logic [DELAY_W-1:0]   delay_ff;
   logic [GAIN_W-1:0]    echo_gain_ff, fb_gain_ff;

   logic                 req_fire, out_free, ram_we;
   logic [CMP_W-1:0]     dl_ext;
   logic [ADDR_W-1:0]    dlc, rp;
   logic [ADDR_W:0]      rp_wrap;
   logic [LINE_W-1:0]    line_word, wr_word;
   logic [SAMPLE_W-1:0]  y_half;
   fed_ctrl_type         ctrl;

   assign req_fire = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign ram_we   = (state_ff == S_WR);

   // read position, delay clamped below the line depth
   always_comb begin
      dl_ext = CMP_W'(delay_ff);
      if (dl_ext >= CMP_W'(LINE_DEPTH)) begin
         dlc = ADDR_W'(LINE_DEPTH - 1);
      end else begin
         dlc = dl_ext[ADDR_W-1:0];
      end
      rp_wrap = {1'b0, wp_ff} + (ADDR_W+1)'(LINE_DEPTH) - {1'b0, dlc};
      if (wp_ff >= dlc) begin
         rp = wp_ff - dlc;
      end else begin
         rp = rp_wrap[ADDR_W-1:0];
      end
   end

   always_comb begin
      ctrl.load_x = req_fire;
      ctrl.mul_s  = (state_ff == S_MUL_S);
      ctrl.mul_b  = (state_ff == S_MUL_B);
   end

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      wrapped_in   = wrapped_ff;
      rd_valid_in  = rd_valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               rd_valid_in = wrapped_ff || (rp < wp_ff);
               state_in    = S_MUL_S;
            end
         end
         S_MUL_S: state_in = S_MUL_B;
         S_MUL_B: state_in = S_WR;
         S_WR: begin
            if (wp_ff == ADDR_W'(LINE_DEPTH - 1)) begin
               wp_in      = '0;
               wrapped_in = 1'b1;
            end else begin
               wp_in = wp_ff + 1'b1;
            end
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = y_half;
               state_in     = S_IDLE;
            end else begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = y_half;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wp_ff        <= '0;
         wrapped_ff   <= 1'b0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         wrapped_ff   <= wrapped_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // configuration registers; bits above a register's width are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff     <= DELAY_RESET;
         echo_gain_ff <= GAIN_RESET;
         fb_gain_ff   <= GAIN_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DELAY_LENGTH:  delay_ff     <= csr_data[DELAY_W-1:0];
            CSR_ECHO_GAIN:     echo_gain_ff <= csr_data[GAIN_W-1:0];
            CSR_FEEDBACK_GAIN: fb_gain_ff   <= csr_data[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   fed_ram #(
      .WIDTH(LINE_W),
      .DEPTH(LINE_DEPTH)
   ) u_line (
      .clock(clock),
      .we   (ram_we),
      .waddr(wp_ff),
      .wdata(wr_word),
      .re   (req_fire),
      .raddr(rp),
      .rdata(line_word)
   );

   fed_datapath u_dp (
      .clock        (clock),
      .ctrl         (ctrl),
      .in_sample    (req_tdata[SAMPLE_W-1:0]),
      .echo_gain    (echo_gain_ff),
      .feedback_gain(fb_gain_ff),
      .line_valid   (rd_valid_ff),
      .line_word    (line_word),
      .y_half       (y_half),
      .wr_word      (wr_word)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   // a read is issued only from idle and the line word is used next cycle
   a_accept_to_mul: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == S_MUL_S)
      else $error("accepted transaction did not enter the multiply stage");

   // every line write advances the write pointer
   a_write_advances: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> wp_ff != $past(wp_ff))
      else $error("write pointer did not advance after a line write");

   // the wrap flag drops only through reset
   a_wrap_sticky: assert property (@(posedge clock) disable iff (reset)
      $fell(wrapped_ff) |-> $past(reset))
      else $error("wrap flag cleared outside reset");

   // a held result forces the wait state after write-back
   a_hold_waits: assert property (@(posedge clock) disable iff (reset)
      (ram_we && !out_free) |=> state_ff == S_OUT && rsp_valid_ff)
      else $error("result overwrote a pending transaction");

endmodule
